// File: hdl/mpq_pkg.sv
// Shared types and constants for the min priority queue.
`timescale 1ns / 1ps
package mpq_pkg;

  localparam int KEY_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int ERR_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;  // insert the broadcast key
    logic ext_en;  // shift every key one place toward the head
    key_t key;
  } cell_ctl_t;

endpackage

// File: hdl/mpq_cell.sv
// One cell of the sorted key row: holds one key and trades with its neighbors.
`timescale 1ns / 1ps
module mpq_cell (
  input  logic              clk,
  input  mpq_pkg::cell_ctl_t ctl,
  input  logic              occ,       // this place holds a key
  input  logic              left_le,   // left neighbor keeps its key on insert
  input  mpq_pkg::key_t     left_key,
  input  mpq_pkg::key_t     right_key,
  output logic              le,        // held key <= broadcast key
  output mpq_pkg::key_t     key
);
  import mpq_pkg::*;

  key_t key_r;
  key_t key_nxt;

  assign le  = occ && (key_r <= ctl.key);
  assign key = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins_en) begin
      if (!le) begin
        key_nxt = left_le ? ctl.key : left_key;
      end
    end else if (ctl.ext_en) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: hdl/min_priority_queue.sv
// Top level of the min priority queue: a sorted row of key cells and a result register.
// A result is registered when its item is accepted, and is valid in the next cycle.
// Throughput: one item per cycle while out_tready drains the result; the key compare
//   broadcast over CAPACITY cells and the neighbor hand-off are combinational.
// Reset (rst_n, synchronous, active low) empties the queue and drops any pending
//   result; the key cells have no reset and are read only below the count.
`timescale 1ns / 1ps
module min_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mpq_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] new_key
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] extracted_key, [32] extracted_valid, [64:33] current_min,
  // [71:65] entry_count, [73:72] error_code, [79:74] zero
  output logic [mpq_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  key_t      cell_key [CAPACITY];
  logic      cell_le  [CAPACITY];
  cell_ctl_t ctl;

  logic in_acc;
  logic is_full;
  logic is_empty;
  key_t new_key;

  // Result register
  logic                 out_valid_r;
  key_t                 res_ext_key_r;
  logic                 res_ext_valid_r;
  key_t                 res_min_r;
  logic [CNT_W-1:0]     res_cnt_r;
  logic [ERR_W-1:0]     res_err_r;
  key_t                 res_ext_key_nxt;
  logic                 res_ext_valid_nxt;
  key_t                 res_min_nxt;
  logic [ERR_W-1:0]     res_err_nxt;

  // Take a new item whenever the result register is free or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign new_key   = key_t'(in_tdata[KEY_W-1:0]);

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign ctl.ins_en = in_acc && (in_tuser == CMD_INSERT) && !is_full;
  assign ctl.ext_en = in_acc && (in_tuser == CMD_EXTRACT) && !is_empty;
  assign ctl.key    = new_key;

  // Row of cells: head at index 0 holds the smallest key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  occ;
    logic  left_le;
    key_t  left_key;
    key_t  right_key;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_le  = 1'b1;
      assign left_key = new_key;
    end else begin : g_body
      assign left_le  = cell_le[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    mpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_le   (left_le),
      .left_key  (left_key),
      .right_key (right_key),
      .le        (cell_le[i]),
      .key       (cell_key[i])
    );
  end

  // Count and result for the item in flight.
  always_comb begin
    count_nxt         = count_r;
    res_ext_key_nxt   = '0;
    res_ext_valid_nxt = 1'b0;
    res_err_nxt       = ERR_OK;
    res_min_nxt       = is_empty ? key_t'(0) : cell_key[0];
    if (in_tuser == CMD_INSERT) begin
      if (is_full) begin
        res_err_nxt = ERR_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (is_empty || (new_key < cell_key[0])) begin
          res_min_nxt = new_key;
        end
      end
    end else begin
      if (is_empty) begin
        res_err_nxt = ERR_EMPTY;
      end else begin
        count_nxt         = count_r - CNT_W'(1);
        res_ext_key_nxt   = cell_key[0];
        res_ext_valid_nxt = 1'b1;
        // Minimum after the shift is the second key, if any.
        res_min_nxt = (count_r > CNT_W'(1)) ? cell_key[1] : key_t'(0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the result: hold while the downstream stalls.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_ext_key_r   <= res_ext_key_nxt;
      res_ext_valid_r <= res_ext_valid_nxt;
      res_min_r       <= res_min_nxt;
      res_cnt_r       <= count_nxt;
      res_err_r       <= res_err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_err_r, CNT_OUT_W'(res_cnt_r), res_min_r,
                       res_ext_valid_r, res_ext_key_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (cell_key[0] <= cell_key[1]))
    else $error("head keys out of order");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_extract_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_ext_valid_r) |-> (res_err_r == ERR_OK))
    else $error("extracted key reported with an error");

  a_err_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == CMD_INSERT) && is_full) |=>
      (res_err_r == ERR_FULL) && (count_r == CNT_W'(CAPACITY)))
    else $error("dropped insert changed the queue");
`endif

endmodule
